// ===== design/ipv4_receive_filter_top_defines.svh =====
// Assertion macros for the IPv4 receive filter.
`ifndef IPV4_RECEIVE_FILTER_TOP_DEFINES_SVH
`define IPV4_RECEIVE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define IRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define IRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define IRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/irf_pkg.sv =====
// Types and constants shared by the IPv4 receive filter files.
`timescale 1ns / 1ps

package irf_pkg;

  typedef enum logic [3:0] {
    VERDICT_ACCEPT    = 4'd0,
    VERDICT_SHORT     = 4'd1,
    VERDICT_VERSION   = 4'd2,
    VERDICT_HDRLEN    = 4'd3,
    VERDICT_TRUNCATED = 4'd4,
    VERDICT_CHECKSUM  = 4'd5,
    VERDICT_NOT_OURS  = 4'd6,
    VERDICT_BAD_SRC   = 4'd7,
    VERDICT_FRAGMENT  = 4'd8
  } verdict_t;

  typedef enum logic [1:0] {
    CLASS_OTHER = 2'd0,
    CLASS_ICMP  = 2'd1,
    CLASS_UDP   = 2'd2,
    CLASS_TCP   = 2'd3
  } proto_class_t;

  typedef enum logic [1:0] {
    REG_LOCAL_ADDRESS   = 2'd0,
    REG_SUBNET_MASK     = 2'd1,
    REG_ADDRESS_VALID   = 2'd2,
    REG_CHECKSUM_BY_NIC = 2'd3
  } cfg_index_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int          MIN_HEADER_BYTES = 20;
  localparam logic [3:0]  IP_VERSION       = 4'd4;
  localparam int          IHL_SHIFT        = 2;   // IHL counts 4-byte words
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [3:0]  MCAST_NIBBLE     = 4'hE;
  localparam logic [15:0] FRAG_MASK        = 16'h3FFF;
  localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;

  // Header byte offsets
  localparam int OFF_VER_IHL  = 0;
  localparam int OFF_TLEN_HI  = 2;
  localparam int OFF_TLEN_LO  = 3;
  localparam int OFF_FRAG_HI  = 6;
  localparam int OFF_FRAG_LO  = 7;
  localparam int OFF_PROTO    = 9;
  localparam int OFF_SRC_LO   = 12;
  localparam int OFF_SRC_HI   = 15;
  localparam int OFF_DST_LO   = 16;
  localparam int OFF_DST_HI   = 19;

endpackage

// ===== design/irf_channels.sv =====
// Valid/ready channel interfaces for packet bytes, verdicts and register writes.
`timescale 1ns / 1ps

interface irf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;
  logic       nic_csum_checked;
  logic       nic_csum_good;

  modport source (output valid, pkt_byte, last_byte, nic_csum_checked, nic_csum_good,
                  input ready);
  modport sink   (input valid, pkt_byte, last_byte, nic_csum_checked, nic_csum_good,
                  output ready);
endinterface

interface irf_verdict_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [1:0]  proto_class;
  logic [7:0]  protocol_number;
  logic [5:0]  header_bytes;
  logic [15:0] payload_bytes;

  modport source (output valid, verdict, proto_class, protocol_number, header_bytes,
                  payload_bytes, input ready);
  modport sink   (input valid, verdict, proto_class, protocol_number, header_bytes,
                  payload_bytes, output ready);
endinterface

interface irf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [irf_pkg::CFG_INDEX_W-1:0] index;
  logic [irf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ipv4_receive_filter_top.sv =====
// IPv4 receive filter: byte-wise header capture, checksum and verdict generation.
// Takes one packet byte per beat, header first, and on the beat flagged last_byte
// gives one verdict beat (accept or the first failing check) with protocol class,
// header size and payload size. One byte is accepted every clock cycle; the only
// stall is back-pressure on the verdict channel, which holds input while a verdict
// waits and out_ch.ready is low. The verdict is registered and shows on out_ch in
// the cycle after the last byte is accepted. Header fields and the ones-complement
// sum are updated in the cycle a byte is taken and the verdict is registered straight
// from those updated values. Register writes are always taken (cfg_ch.ready is tied
// high) and must only happen while no packet is in flight.
`timescale 1ns / 1ps
`include "ipv4_receive_filter_top_defines.svh"

module ipv4_receive_filter_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  irf_byte_if.sink      in_ch,
  irf_verdict_if.source out_ch,
  irf_cfg_if.sink       cfg_ch
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration
  logic [31:0] local_addr_r;
  logic [31:0] subnet_mask_r;
  logic        addr_valid_r;
  logic        csum_by_nic_r;

  // per-packet state
  logic [COUNT_WIDTH-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]  version_ihl_r, version_ihl_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [15:0] frag_field_r, frag_field_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [31:0] src_addr_r, src_addr_nxt;
  logic [31:0] dst_addr_r, dst_addr_nxt;
  logic [7:0]  high_hold_r, high_hold_nxt;
  logic [15:0] ones_sum_r, ones_sum_nxt;

  // verdict register
  logic                  out_valid_r;
  irf_pkg::verdict_t     verdict_r, verdict_nxt;
  irf_pkg::proto_class_t class_r, class_nxt;
  logic [7:0]            proto_num_r;
  logic [5:0]            hdr_bytes_r;
  logic [15:0]           payload_r, payload_nxt;

  logic                   in_ready;
  logic                   in_acc;
  logic [COUNT_WIDTH-1:0] pos;
  logic [5:0]             hlen;
  logic [16:0]            sum_wide;
  logic                   dst_bcast;
  logic                   not_ours;
  logic                   src_bad;
  logic                   csum_bad;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      subnet_mask_r <= '0;
      addr_valid_r  <= 1'b0;
      csum_by_nic_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (irf_pkg::cfg_index_t'(cfg_ch.index))
        irf_pkg::REG_LOCAL_ADDRESS:   local_addr_r  <= cfg_ch.data;
        irf_pkg::REG_SUBNET_MASK:     subnet_mask_r <= cfg_ch.data;
        irf_pkg::REG_ADDRESS_VALID:   addr_valid_r  <= cfg_ch.data[0];
        irf_pkg::REG_CHECKSUM_BY_NIC: csum_by_nic_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // header capture and running sum for this beat
  always_comb begin
    pos              = byte_count_r;
    version_ihl_nxt  = version_ihl_r;
    total_length_nxt = total_length_r;
    frag_field_nxt   = frag_field_r;
    protocol_nxt     = protocol_r;
    src_addr_nxt     = src_addr_r;
    dst_addr_nxt     = dst_addr_r;
    high_hold_nxt    = high_hold_r;
    ones_sum_nxt     = ones_sum_r;
    sum_wide         = '0;

    if (pos == COUNT_WIDTH'(irf_pkg::OFF_VER_IHL)) version_ihl_nxt = in_ch.pkt_byte;
    hlen = {version_ihl_nxt[3:0], {irf_pkg::IHL_SHIFT{1'b0}}};

    if (pos == COUNT_WIDTH'(irf_pkg::OFF_TLEN_HI))
      total_length_nxt = {in_ch.pkt_byte, total_length_r[7:0]};
    if (pos == COUNT_WIDTH'(irf_pkg::OFF_TLEN_LO))
      total_length_nxt = {total_length_r[15:8], in_ch.pkt_byte};
    if (pos == COUNT_WIDTH'(irf_pkg::OFF_FRAG_HI))
      frag_field_nxt = {in_ch.pkt_byte, frag_field_r[7:0]};
    if (pos == COUNT_WIDTH'(irf_pkg::OFF_FRAG_LO))
      frag_field_nxt = {frag_field_r[15:8], in_ch.pkt_byte};
    if (pos == COUNT_WIDTH'(irf_pkg::OFF_PROTO))
      protocol_nxt = in_ch.pkt_byte;
    if (pos >= COUNT_WIDTH'(irf_pkg::OFF_SRC_LO) && pos <= COUNT_WIDTH'(irf_pkg::OFF_SRC_HI))
      src_addr_nxt = {src_addr_r[23:0], in_ch.pkt_byte};
    if (pos >= COUNT_WIDTH'(irf_pkg::OFF_DST_LO) && pos <= COUNT_WIDTH'(irf_pkg::OFF_DST_HI))
      dst_addr_nxt = {dst_addr_r[23:0], in_ch.pkt_byte};

    // header words only; sum stays folded to 16 bits
    if (pos < COUNT_WIDTH'(hlen)) begin
      if (!pos[0]) begin
        high_hold_nxt = in_ch.pkt_byte;
      end else begin
        sum_wide     = {1'b0, ones_sum_r} + {1'b0, high_hold_r, in_ch.pkt_byte};
        ones_sum_nxt = sum_wide[15:0] + 16'(sum_wide[16]);
      end
    end

    byte_count_nxt = (pos != COUNT_MAX) ? pos + 1'b1 : pos;
  end

  // verdict from the updated fields
  always_comb begin
    csum_bad = csum_by_nic_r ? !(in_ch.nic_csum_checked && in_ch.nic_csum_good)
                             : (ones_sum_nxt != irf_pkg::CSUM_GOOD);

    if (dst_addr_nxt == '1)
      dst_bcast = 1'b1;
    else if (dst_addr_nxt == local_addr_r)
      dst_bcast = 1'b0;
    else
      dst_bcast = ((dst_addr_nxt & subnet_mask_r) == (local_addr_r & subnet_mask_r)) &&
                  ((dst_addr_nxt & ~subnet_mask_r) == ~subnet_mask_r);

    not_ours = (protocol_nxt != irf_pkg::PROTO_UDP) &&
               (!addr_valid_r || (!dst_bcast && dst_addr_nxt != local_addr_r));
    src_bad  = (src_addr_nxt == '1) || (src_addr_nxt[31:28] == irf_pkg::MCAST_NIBBLE);

    if (byte_count_nxt < COUNT_WIDTH'(irf_pkg::MIN_HEADER_BYTES))
      verdict_nxt = irf_pkg::VERDICT_SHORT;
    else if (version_ihl_nxt[7:4] != irf_pkg::IP_VERSION)
      verdict_nxt = irf_pkg::VERDICT_VERSION;
    else if (hlen < 6'(irf_pkg::MIN_HEADER_BYTES) || total_length_nxt < 16'(hlen))
      verdict_nxt = irf_pkg::VERDICT_HDRLEN;
    else if (byte_count_nxt < COUNT_WIDTH'(total_length_nxt))
      verdict_nxt = irf_pkg::VERDICT_TRUNCATED;
    else if (csum_bad)
      verdict_nxt = irf_pkg::VERDICT_CHECKSUM;
    else if (not_ours)
      verdict_nxt = irf_pkg::VERDICT_NOT_OURS;
    else if (src_bad)
      verdict_nxt = irf_pkg::VERDICT_BAD_SRC;
    else if ((frag_field_nxt & irf_pkg::FRAG_MASK) != '0)
      verdict_nxt = irf_pkg::VERDICT_FRAGMENT;
    else
      verdict_nxt = irf_pkg::VERDICT_ACCEPT;

    case (protocol_nxt)
      irf_pkg::PROTO_ICMP: class_nxt = irf_pkg::CLASS_ICMP;
      irf_pkg::PROTO_UDP:  class_nxt = irf_pkg::CLASS_UDP;
      irf_pkg::PROTO_TCP:  class_nxt = irf_pkg::CLASS_TCP;
      default:             class_nxt = irf_pkg::CLASS_OTHER;
    endcase

    payload_nxt = (verdict_nxt == irf_pkg::VERDICT_ACCEPT)
                  ? total_length_nxt - 16'(hlen) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      version_ihl_r  <= '0;
      total_length_r <= '0;
      frag_field_r   <= '0;
      protocol_r     <= '0;
      src_addr_r     <= '0;
      dst_addr_r     <= '0;
      high_hold_r    <= '0;
      ones_sum_r     <= '0;
    end else if (in_acc) begin
      if (in_ch.last_byte) begin
        // packet done: start clean for the next one
        byte_count_r   <= '0;
        version_ihl_r  <= '0;
        total_length_r <= '0;
        frag_field_r   <= '0;
        protocol_r     <= '0;
        src_addr_r     <= '0;
        dst_addr_r     <= '0;
        high_hold_r    <= '0;
        ones_sum_r     <= '0;
      end else begin
        byte_count_r   <= byte_count_nxt;
        version_ihl_r  <= version_ihl_nxt;
        total_length_r <= total_length_nxt;
        frag_field_r   <= frag_field_nxt;
        protocol_r     <= protocol_nxt;
        src_addr_r     <= src_addr_nxt;
        dst_addr_r     <= dst_addr_nxt;
        high_hold_r    <= high_hold_nxt;
        ones_sum_r     <= ones_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_byte) begin
      verdict_r   <= verdict_nxt;
      class_r     <= class_nxt;
      proto_num_r <= protocol_nxt;
      hdr_bytes_r <= hlen;
      payload_r   <= payload_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.verdict         = verdict_r;
  assign out_ch.proto_class     = class_r;
  assign out_ch.protocol_number = proto_num_r;
  assign out_ch.header_bytes    = hdr_bytes_r;
  assign out_ch.payload_bytes   = payload_r;

  `IRF_ASSERT_NEXT(a_verdict_follows_last, clk, rst_n, in_acc && in_ch.last_byte, out_valid_r, "no verdict after last byte")
  `IRF_ASSERT_NEXT(a_count_cleared, clk, rst_n, in_acc && in_ch.last_byte, byte_count_r == '0, "byte count not cleared after packet")
  `IRF_ASSERT_IMPL(a_accept_hdr_min, clk, rst_n, out_valid_r && verdict_r == irf_pkg::VERDICT_ACCEPT, hdr_bytes_r >= 6'(irf_pkg::MIN_HEADER_BYTES), "accepted packet with short header")
  `IRF_ASSERT_IMPL(a_reject_no_payload, clk, rst_n, out_valid_r && verdict_r != irf_pkg::VERDICT_ACCEPT, payload_r == '0, "payload size on rejected packet")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the IPv4 receive filter: byte driver, verdict monitor, predictor.
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 4;     // verdict lands in the cycle after the last byte
  localparam int DRAIN_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_GAP       = 17;

  typedef logic [7:0] octet_q_t[$];

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       nic_chk;
    logic       nic_ok;
    int         gap;
  } byte_item_t;

  typedef struct {
    irf_pkg::verdict_t     verdict;
    irf_pkg::proto_class_t cls;
    logic [7:0]            proto;
    logic [5:0]            hdr_bytes;
    logic [15:0]           payload;
  } verdict_rec_t;

  typedef struct {
    int          ihl;
    logic [3:0]  version;
    logic [15:0] tot_len;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    bit          csum_ok;
    int          body;
    int          cut;
  } hdr_spec_t;

  logic clk;
  logic rst_n;

  irf_byte_if    in_ch();
  irf_verdict_if out_ch();
  irf_cfg_if     cfg_ch();

  ipv4_receive_filter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the register file
  logic [31:0] cfg_addr;
  logic [31:0] cfg_mask;
  logic        cfg_addr_valid;
  logic        cfg_nic_csum;

  // per-packet state of the filter, as the predictor sees it
  logic [15:0] pkt_count;
  logic [7:0]  ver_ihl;
  logic [15:0] tot_len;
  logic [15:0] frag_word;
  logic [7:0]  proto_byte;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  hi_hold;
  logic [19:0] hdr_sum;

  byte_item_t   pending_bytes[$];
  verdict_rec_t expected_verdicts[$];
  byte_item_t   cur_item;
  verdict_rec_t want;

  int  gap_wait;
  int  rx_stall;
  int  hold_left;
  bit  hold_done;
  int  verdicts_seen;
  bit  calm;
  int  mismatches;
  int  packets_sent;
  int  bytes_sent;
  int  settings_used;
  int  verdict_tally[9];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // Predictor: takes one accepted byte, queues the verdict on the last one.
  task automatic predict_byte(input byte_item_t it);
    logic [15:0]  pos;
    logic [5:0]   hlen;
    logic [19:0]  acc;
    logic         dst_ok;
    verdict_rec_t rec;
    pos = pkt_count;
    if (pos == irf_pkg::OFF_VER_IHL) ver_ihl = it.data;
    hlen = 6'(ver_ihl[3:0]) << irf_pkg::IHL_SHIFT;
    if (pos == irf_pkg::OFF_TLEN_HI) tot_len[15:8] = it.data;
    if (pos == irf_pkg::OFF_TLEN_LO) tot_len[7:0] = it.data;
    if (pos == irf_pkg::OFF_FRAG_HI) frag_word[15:8] = it.data;
    if (pos == irf_pkg::OFF_FRAG_LO) frag_word[7:0] = it.data;
    if (pos == irf_pkg::OFF_PROTO) proto_byte = it.data;
    if (pos >= irf_pkg::OFF_SRC_LO && pos <= irf_pkg::OFF_SRC_HI)
      src_addr = {src_addr[23:0], it.data};
    if (pos >= irf_pkg::OFF_DST_LO && pos <= irf_pkg::OFF_DST_HI)
      dst_addr = {dst_addr[23:0], it.data};
    if (pos < hlen) begin
      if (!pos[0]) begin
        hi_hold = it.data;
      end else begin
        acc = hdr_sum + {hi_hold, it.data};
        hdr_sum = acc[15:0] + acc[19:16];
      end
    end
    if (pkt_count != '1) pkt_count++;
    if (it.last) begin
      // broadcast on the subnet means every host bit set
      dst_ok = dst_addr == '1 || dst_addr == cfg_addr ||
               ((dst_addr & cfg_mask) == (cfg_addr & cfg_mask) &&
                (dst_addr & ~cfg_mask) == ~cfg_mask);
      if (pkt_count < irf_pkg::MIN_HEADER_BYTES)
        rec.verdict = irf_pkg::VERDICT_SHORT;
      else if (ver_ihl[7:4] != irf_pkg::IP_VERSION)
        rec.verdict = irf_pkg::VERDICT_VERSION;
      else if (hlen < irf_pkg::MIN_HEADER_BYTES || tot_len < hlen)
        rec.verdict = irf_pkg::VERDICT_HDRLEN;
      else if (pkt_count < tot_len)
        rec.verdict = irf_pkg::VERDICT_TRUNCATED;
      else if (cfg_nic_csum ? !(it.nic_chk && it.nic_ok)
                            : (hdr_sum != 20'(irf_pkg::CSUM_GOOD)))
        rec.verdict = irf_pkg::VERDICT_CHECKSUM;
      else if (proto_byte != irf_pkg::PROTO_UDP && (!cfg_addr_valid || !dst_ok))
        rec.verdict = irf_pkg::VERDICT_NOT_OURS;
      else if (src_addr == '1 || src_addr[31:28] == irf_pkg::MCAST_NIBBLE)
        rec.verdict = irf_pkg::VERDICT_BAD_SRC;
      else if ((frag_word & irf_pkg::FRAG_MASK) != 0)
        rec.verdict = irf_pkg::VERDICT_FRAGMENT;
      else
        rec.verdict = irf_pkg::VERDICT_ACCEPT;
      case (proto_byte)
        irf_pkg::PROTO_ICMP: rec.cls = irf_pkg::CLASS_ICMP;
        irf_pkg::PROTO_UDP:  rec.cls = irf_pkg::CLASS_UDP;
        irf_pkg::PROTO_TCP:  rec.cls = irf_pkg::CLASS_TCP;
        default:             rec.cls = irf_pkg::CLASS_OTHER;
      endcase
      rec.proto     = proto_byte;
      rec.hdr_bytes = hlen;
      rec.payload   = (rec.verdict == irf_pkg::VERDICT_ACCEPT) ? tot_len - 16'(hlen) : 16'd0;
      expected_verdicts.push_back(rec);
      verdict_tally[rec.verdict]++;
      pkt_count = '0; ver_ihl = '0; tot_len = '0; frag_word = '0; proto_byte = '0;
      src_addr = '0; dst_addr = '0; hi_hold = '0; hdr_sum = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_byte(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && gap_wait >= pending_bytes[0].gap) begin
          cur_item = pending_bytes.pop_front();
          gap_wait = 0;
          in_ch.valid            <= 1'b1;
          in_ch.pkt_byte         <= cur_item.data;
          in_ch.last_byte        <= cur_item.last;
          in_ch.nic_csum_checked <= cur_item.nic_chk;
          in_ch.nic_csum_good    <= cur_item.nic_ok;
        end else begin
          in_ch.valid <= 1'b0;
          if (pending_bytes.size() != 0) gap_wait++;
        end
      end
    end
  end

  // Verdict monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      verdicts_seen <= 0;
      rx_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen <= verdicts_seen + 1;
        if (expected_verdicts.size() == 0) begin
          $error("verdict beat with nothing expected: verdict %0d", out_ch.verdict);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("verdict", want.verdict, out_ch.verdict);
          check_field("proto_class", want.cls, out_ch.proto_class);
          check_field("protocol_number", want.proto, out_ch.protocol_number);
          check_field("header_bytes", want.hdr_bytes, out_ch.header_bytes);
          check_field("payload_bytes", want.payload, out_ch.payload_bytes);
        end
        rx_stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One long output stall while plenty of bytes are still queued, so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && verdicts_seen >= 5 && pending_bytes.size() > 30) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic write_reg(input irf_pkg::cfg_index_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      irf_pkg::REG_LOCAL_ADDRESS:   cfg_addr = val;
      irf_pkg::REG_SUBNET_MASK:     cfg_mask = val;
      irf_pkg::REG_ADDRESS_VALID:   cfg_addr_valid = val[0];
      irf_pkg::REG_CHECKSUM_BY_NIC: cfg_nic_csum = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] addr, input logic [31:0] netmask,
                            input logic addr_ok, input logic nic_csum);
    write_reg(irf_pkg::REG_LOCAL_ADDRESS, addr);
    write_reg(irf_pkg::REG_SUBNET_MASK, netmask);
    write_reg(irf_pkg::REG_ADDRESS_VALID, {31'd0, addr_ok});
    write_reg(irf_pkg::REG_CHECKSUM_BY_NIC, {31'd0, nic_csum});
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Waits until every byte is in and every verdict out, then lets the block settle.
  task automatic wait_drained();
    int spin;
    spin = 0;
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid ||
           (expected_verdicts.size() != 0 && spin < DRAIN_LIMIT)) begin
      if (pending_bytes.size() == 0 && !in_ch.valid) spin++;
      @(negedge clk);
    end
    if (expected_verdicts.size() != 0) begin
      $error("verdict: expected %0d more beats, got none", expected_verdicts.size());
      mismatches += expected_verdicts.size();
      expected_verdicts.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_octets(input octet_q_t pkt, input bit nic_pass, input bit no_gaps);
    byte_item_t it;
    foreach (pkt[i]) begin
      it.data = pkt[i];
      it.last = (i == pkt.size() - 1);
      if (it.last) {it.nic_chk, it.nic_ok} = nic_pass ? 2'b11 : 2'($urandom_range(0, 2));
      else {it.nic_chk, it.nic_ok} = 2'($urandom_range(0, 3));
      it.gap = (no_gaps || calm) ? 0 : $urandom_range(0, MAX_GAP);
      pending_bytes.push_back(it);
    end
    packets_sent++;
    bytes_sent += pkt.size();
  endtask

  task automatic queue_spec(input hdr_spec_t s, input bit nic_pass, input bit no_gaps);
    octet_q_t    pkt;
    int          hdr_gen;
    logic [19:0] acc;
    logic [15:0] csum;
    hdr_gen = (s.ihl * 4 < irf_pkg::MIN_HEADER_BYTES) ? irf_pkg::MIN_HEADER_BYTES : s.ihl * 4;
    for (int i = 0; i < hdr_gen + s.body; i++) pkt.push_back(8'($urandom_range(0, 255)));
    pkt[irf_pkg::OFF_VER_IHL] = {s.version, 4'(s.ihl)};
    pkt[irf_pkg::OFF_TLEN_HI] = s.tot_len[15:8];
    pkt[irf_pkg::OFF_TLEN_LO] = s.tot_len[7:0];
    pkt[irf_pkg::OFF_FRAG_HI] = s.frag[15:8];
    pkt[irf_pkg::OFF_FRAG_LO] = s.frag[7:0];
    pkt[irf_pkg::OFF_PROTO]   = s.proto;
    pkt[10] = 8'd0;
    pkt[11] = 8'd0;
    for (int k = 0; k < 4; k++) begin
      pkt[irf_pkg::OFF_SRC_LO + k] = s.src[31 - 8 * k -: 8];
      pkt[irf_pkg::OFF_DST_LO + k] = s.dst[31 - 8 * k -: 8];
    end
    acc = '0;
    for (int i = 0; i + 1 < s.ihl * 4; i += 2) begin
      acc = acc + {pkt[i], pkt[i + 1]};
      acc = acc[15:0] + acc[19:16];
    end
    csum = ~acc[15:0];
    if (!s.csum_ok) csum ^= 16'($urandom_range(1, 65535));
    pkt[10] = csum[15:8];
    pkt[11] = csum[7:0];
    repeat (s.cut) if (pkt.size() > 1) pkt.delete(pkt.size() - 1);
    send_octets(pkt, nic_pass, no_gaps);
  endtask

  function automatic hdr_spec_t good_spec(input logic [7:0] proto, input logic [31:0] dst,
                                          input int payload);
    hdr_spec_t s;
    s.ihl     = 5;
    s.version = irf_pkg::IP_VERSION;
    s.tot_len = 16'(20 + payload);
    s.frag    = 16'd0;
    s.proto   = proto;
    s.src     = {8'd10, 24'($urandom)};
    s.dst     = dst;
    s.csum_ok = 1'b1;
    s.body    = payload;
    s.cut     = 0;
    return s;
  endfunction

  // Mostly well-formed packets aimed at the interface, with random content
  function automatic hdr_spec_t random_spec();
    hdr_spec_t s;
    logic [31:0] dst;
    case ($urandom_range(0, 4))
      0: dst = cfg_addr;
      1: dst = '1;
      2: dst = cfg_addr | ~cfg_mask;
      3: dst = (cfg_addr & cfg_mask) | ($urandom & ~cfg_mask);
      default: dst = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0: s = good_spec(irf_pkg::PROTO_ICMP, dst, $urandom_range(0, 16));
      1: s = good_spec(irf_pkg::PROTO_TCP, dst, $urandom_range(0, 16));
      2, 3: s = good_spec(irf_pkg::PROTO_UDP, dst, $urandom_range(0, 16));
      default: s = good_spec(8'($urandom_range(0, 255)), dst, $urandom_range(0, 16));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      s.ihl = $urandom_range(5, 15);
      s.tot_len = 16'(s.ihl * 4 + s.body);
    end
    if ($urandom_range(0, 4) == 0) s.body += $urandom_range(1, 3);
    case ($urandom_range(0, 9))
      0: s.src = '1;
      1: s.src = {irf_pkg::MCAST_NIBBLE, 28'($urandom)};
      2, 3: s.src = $urandom;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: s.frag = 16'($urandom);
      1: s.frag = 16'($urandom_range(1, 3)) << 13;
      2, 3, 4: s.frag = 16'h4000;
      default: s.frag = 16'd0;
    endcase
    s.csum_ok = $urandom_range(0, 9) != 0;
    return s;
  endfunction

  task automatic queue_random_packet();
    int        kind;
    octet_q_t  noise;
    hdr_spec_t s;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 40)) noise.push_back(8'($urandom_range(0, 255)));
      send_octets(noise, 1'($urandom_range(0, 1)), 1'b0);
    end else begin
      s = random_spec();
      if (kind < 35) begin
        case ($urandom_range(0, 5))
          0: s.version = 4'($urandom_range(0, 15));
          1: s.ihl = $urandom_range(0, 4);
          2: s.tot_len = 16'($urandom_range(0, s.ihl * 4 - 1));
          3: s.cut = $urandom_range(1, s.body + 15);
          4: s.csum_ok = 1'b0;
          default: s.tot_len = 16'($urandom);
        endcase
      end
      queue_spec(s, $urandom_range(0, 9) < 7, 1'b0);
    end
  endtask

  initial begin
    hdr_spec_t s;
    octet_q_t  one;
    int        rnd_packets;
    int        rnd_bytes;
    int        phase;
    logic [31:0] netmask;
    int          prefix;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pkt_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    in_ch.nic_csum_checked = 1'b0;
    in_ch.nic_csum_good = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = irf_pkg::REG_LOCAL_ADDRESS;
    cfg_ch.data = '0;
    cfg_addr = '0; cfg_mask = '0; cfg_addr_valid = 1'b0; cfg_nic_csum = 1'b0;
    pkt_count = '0; ver_ihl = '0; tot_len = '0; frag_word = '0; proto_byte = '0;
    src_addr = '0; dst_addr = '0; hi_hold = '0; hdr_sum = '0;
    calm = 1'b0;
    mismatches = 0;
    packets_sent = 0;
    bytes_sent = 0;
    settings_used = 1;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no address, so only UDP gets through the destination check
    one.push_back(8'hFF);
    send_octets(one, 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_TCP, 32'h0, 4), 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_UDP, 32'h0, 0), 1'b0, 1'b0);
    wait_drained();

    set_config(32'hC0A8010A, 32'hFFFFFF00, 1'b1, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 0); s.cut = 1;     // header cut at 19 bytes
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 2); s.version = 4'd6;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 2); s.ihl = 4;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 2); s.tot_len = 16'd10;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 20); s.cut = 5;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 3); s.csum_ok = 1'b0;
    queue_spec(s, 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 5), 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_ICMP, 32'hC0A801FF, 1), 1'b0, 1'b0);
    queue_spec(good_spec(8'h2F, 32'hFFFFFFFF, 0), 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_TCP, 32'h0A000001, 0), 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_UDP, 32'h0A000001, 0), 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_UDP, 32'hC0A8010A, 0); s.src = '1;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_UDP, 32'hC0A8010A, 0); s.src = 32'hE0000001;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_UDP, 32'hC0A8010A, 0); s.frag = 16'h2000;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_UDP, 32'hC0A8010A, 0); s.frag = 16'h0001;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_UDP, 32'hC0A8010A, 0); s.frag = 16'h4000;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_UDP, 32'hC0A8010A, 0); s.frag = 16'hFFFF;
    queue_spec(s, 1'b0, 1'b0);
    s = good_spec(irf_pkg::PROTO_TCP, 32'hC0A8010A, 3); s.ihl = 15; s.tot_len = 16'd63;
    queue_spec(s, 1'b0, 1'b0);
    wait_drained();

    // Card checksum flags replace the computed sum
    set_config(32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1);
    s = good_spec(irf_pkg::PROTO_UDP, 32'h01020304, 2); s.csum_ok = 1'b0;
    queue_spec(s, 1'b1, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_UDP, 32'h01020304, 2), 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_TCP, 32'hFFFFFFFF, 2), 1'b1, 1'b0);
    wait_drained();

    set_config(32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_ICMP, 32'h00000000, 1), 1'b0, 1'b0);
    queue_spec(good_spec(irf_pkg::PROTO_UDP, 32'h00000000, 1), 1'b0, 1'b0);
    wait_drained();

    rnd_packets = 0;
    rnd_bytes = 0;
    phase = 0;
    while (rnd_packets < 4 || rnd_bytes < 60) begin
      prefix = $urandom_range(0, 32);
      netmask = ($urandom_range(0, 4) == 0) ? $urandom : 32'hFFFFFFFF << (32 - prefix);
      set_config($urandom, netmask, $urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0);
      calm = (phase % 2 == 1);
      rnd_bytes -= bytes_sent;
      rnd_packets -= packets_sent;
      repeat (2) queue_random_packet();
      rnd_bytes += bytes_sent;
      rnd_packets += packets_sent;
      wait_drained();
      phase++;
    end
    calm = 1'b0;
    wait_drained();

    $display("Run: %0d packets, %0d bytes, %0d register settings, one long verdict hold,",
             packets_sent, bytes_sent, settings_used);
    $display("  verdicts (accept..fragment): %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4], verdict_tally[5], verdict_tally[6], verdict_tally[7],
             verdict_tally[8]);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/irf_pkg.sv
design/irf_channels.sv
design/ipv4_receive_filter_top.sv
sim/tb.sv
